[hw/rtl/chte_pkg.sv]
// shared types and codes for the chained hash table engine
`timescale 1ns / 1ps

package chte_pkg;

    localparam int HASH_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int BCFG_W  = 7;
    localparam int PCFG_W  = 13;
    localparam int CFGI_W  = 1;

    // request types
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_BUCKETS = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_POOL    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic       hash_upd;
        logic       div_ld_bkt;
        logic       div_ld_pool;
        logic       div_step;
        logic       bkt_save;
        logic       scan_rd;
        logic       alloc_wr;
        logic       cur_from_head;
        logic       advance;
        logic       head_wr_slot;
        logic       link_wr;
        logic       unlink;
        logic       clr;
        logic       finish;
        logic       found_sel;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic       clr_done;
        logic       div_done;
        logic       used_q;
        logic       tries_done;
        logic       head_nil;
        logic       next_nil;
        logic       key_match;
        logic [1:0] req;
    } t_dp_stat;

endpackage

[hw/rtl/chte_dp.sv]
// datapath: hashes, shared remainder unit, node pool and chain head memories
`timescale 1ns / 1ps

module chte_dp #(
    parameter int POOL_DEPTH   = 4096,
    parameter int BUCKET_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chte_pkg::t_dp_cmd                   i_cmd,
    output chte_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [chte_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [chte_pkg::PCFG_W-1:0]         i_cfg_data,
    input  logic [1:0]                          i_req_type,
    input  logic                                i_has_char,
    input  logic signed [chte_pkg::CHAR_W-1:0]  i_key_char,
    input  logic [chte_pkg::HASH_W-1:0]         i_entry_value,
    output logic [1:0]                          o_status,
    output logic [chte_pkg::HASH_W-1:0]         o_found_value,
    output logic                                o_done
);

    localparam int HW    = chte_pkg::HASH_W;
    localparam int IW    = $clog2(POOL_DEPTH);
    localparam int PW    = $clog2(POOL_DEPTH + 1);
    localparam int BIW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int DVW   = (PW > chte_pkg::BCFG_W) ? PW : chte_pkg::BCFG_W;
    localparam int CNT_W = $clog2(HW + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

    // configuration and control registers
    logic [chte_pkg::BCFG_W-1:0] r_bcfg;
    logic [chte_pkg::PCFG_W-1:0] r_pcfg;
    logic [HW-1:0]               r_h37;
    logic [HW-1:0]               r_h31;
    logic [IW-1:0]               r_nfs;
    logic [IW-1:0]               r_clr;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_done;
    logic [BUCKET_DEPTH-1:0]     r_head_vld;

    // payload registers
    logic [1:0]     r_req;
    logic [HW-1:0]  r_value;
    logic [HW-1:0]  r_dvd;
    logic [DVW-1:0] r_dvs;
    logic [DVW-1:0] r_rem;
    logic [BIW-1:0] r_bucket;
    logic [IW-1:0]  r_idx;
    logic [PW-1:0]  r_tries;
    logic           r_first;
    logic [PW-1:0]  r_cur;
    logic [PW-1:0]  r_prev;
    logic [1:0]     r_status;
    logic [HW-1:0]  r_found;

    // memories and their registered read data
    logic [PW-1:0] r_next_mem [POOL_DEPTH];
    logic [HW-1:0] r_key_mem  [POOL_DEPTH];
    logic [HW-1:0] r_val_mem  [POOL_DEPTH];
    logic          r_used_mem [POOL_DEPTH];
    logic [PW-1:0] r_head_mem [BUCKET_DEPTH];
    logic [PW-1:0] r_next_q;
    logic [HW-1:0] r_key_q;
    logic [HW-1:0] r_val_q;
    logic          r_used_q;
    logic [PW-1:0] r_head_q;
    logic          r_head_vld_q;

    logic [DVW-1:0] eff_b;
    logic [PW-1:0]  eff_p;
    logic [HW-1:0]  c_ext;
    logic           char_ok;
    logic [HW-1:0]  h37_new;
    logic [HW-1:0]  h31_new;
    logic [DVW:0]   div_trial;
    logic [DVW:0]   div_diff;
    logic [DVW-1:0] div_rem_n;
    logic [PW-1:0]  nfs_p1;
    logic [IW-1:0]  nfs_wrap;
    logic [PW-1:0]  head_val;
    logic           prev_nil;

    logic           next_we;
    logic [IW-1:0]  next_addr;
    logic [PW-1:0]  next_wd;
    logic           used_we;
    logic [IW-1:0]  used_addr;
    logic           used_wd;
    logic           head_we;
    logic [PW-1:0]  head_wd;

    // effective bucket and pool counts
    always_comb begin
        if (r_bcfg == '0) begin
            eff_b = DVW'(1);
        end else if (32'(r_bcfg) > BUCKET_DEPTH) begin
            eff_b = DVW'(BUCKET_DEPTH);
        end else begin
            eff_b = DVW'(r_bcfg);
        end
        if (r_pcfg == '0) begin
            eff_p = PW'(1);
        end else if (32'(r_pcfg) > POOL_DEPTH) begin
            eff_p = PW'(POOL_DEPTH);
        end else begin
            eff_p = PW'(r_pcfg);
        end
    end

    // running hashes, times 37 and times 31 by shift and add or subtract
    assign char_ok = i_has_char && (i_key_char != '0);
    assign c_ext   = {{(HW - chte_pkg::CHAR_W){i_key_char[chte_pkg::CHAR_W-1]}}, i_key_char};
    assign h37_new = char_ok ? ((r_h37 << 5) + (r_h37 << 2) + r_h37 + c_ext) : r_h37;
    assign h31_new = char_ok ? ((r_h31 << 5) - r_h31 + c_ext) : r_h31;

    // one restoring remainder step per cycle
    assign div_trial = {r_rem, r_dvd[HW-1]};
    assign div_diff  = div_trial - {1'b0, r_dvs};
    assign div_rem_n = (div_trial >= {1'b0, r_dvs}) ? div_diff[DVW-1:0] : div_trial[DVW-1:0];

    // round-robin free slot pointer
    assign nfs_p1   = PW'(r_nfs) + PW'(1);
    assign nfs_wrap = (nfs_p1 == eff_p) ? '0 : IW'(nfs_p1);

    assign head_val = r_head_vld_q ? r_head_q : NIL;
    assign prev_nil = (r_prev >= NIL);

    // status back to the controller
    always_comb begin
        o_stat.clr_done   = (r_clr == IW'(POOL_DEPTH - 1));
        o_stat.div_done   = (r_cnt == CNT_W'(HW));
        o_stat.used_q     = r_used_q;
        o_stat.tries_done = (r_tries == eff_p);
        o_stat.head_nil   = (head_val >= NIL);
        o_stat.next_nil   = (r_next_q >= NIL);
        o_stat.key_match  = (r_key_q == r_h31);
        o_stat.req        = r_req;
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcfg     <= chte_pkg::BCFG_W'(61);
            r_pcfg     <= chte_pkg::PCFG_W'(3400);
            r_h37      <= '0;
            r_h31      <= '0;
            r_nfs      <= '0;
            r_clr      <= '0;
            r_cnt      <= '0;
            r_done     <= 1'b0;
            r_head_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    chte_pkg::CFG_BUCKETS: r_bcfg <= i_cfg_data[chte_pkg::BCFG_W-1:0];
                    chte_pkg::CFG_POOL:    r_pcfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_h37 <= '0;
                r_h31 <= '0;
            end else if (i_cmd.hash_upd) begin
                r_h37 <= h37_new;
                r_h31 <= h31_new;
            end
            if (i_cmd.scan_rd) begin
                r_nfs <= r_first ? IW'(r_rem) : nfs_wrap;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.div_ld_bkt || i_cmd.div_ld_pool) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (head_we) begin
                r_head_vld[r_bucket] <= 1'b1;
            end
            r_done <= i_cmd.finish;
        end
    end

    // transaction payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_upd) begin
            r_req   <= i_req_type;
            r_value <= i_entry_value;
        end
        if (i_cmd.div_ld_bkt) begin
            r_dvd <= h37_new;
            r_dvs <= eff_b;
            r_rem <= '0;
        end else if (i_cmd.div_ld_pool) begin
            r_dvd   <= HW'(nfs_p1);
            r_dvs   <= DVW'(eff_p);
            r_rem   <= '0;
            r_first <= 1'b1;
            r_tries <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= div_rem_n;
        end
        if (i_cmd.bkt_save) begin
            r_bucket <= BIW'(r_rem);
        end
        if (i_cmd.scan_rd) begin
            r_idx   <= r_nfs;
            r_first <= 1'b0;
            r_tries <= r_tries + PW'(1);
        end
        if (i_cmd.cur_from_head) begin
            r_cur  <= head_val;
            r_prev <= NIL;
        end else if (i_cmd.advance) begin
            r_prev <= r_cur;
            r_cur  <= r_next_q;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            r_found  <= i_cmd.found_sel ? r_val_q : '0;
        end
    end

    // memory write port selection
    always_comb begin
        next_we   = 1'b0;
        next_addr = r_idx;
        next_wd   = NIL;
        if (i_cmd.alloc_wr) begin
            next_we = 1'b1;
        end else if (i_cmd.link_wr) begin
            next_we   = 1'b1;
            next_addr = r_cur[IW-1:0];
            next_wd   = PW'(r_idx);
        end else if (i_cmd.unlink && !prev_nil) begin
            next_we   = 1'b1;
            next_addr = r_prev[IW-1:0];
            next_wd   = r_next_q;
        end

        used_we   = 1'b0;
        used_addr = r_idx;
        used_wd   = 1'b0;
        if (i_cmd.clr) begin
            used_we   = 1'b1;
            used_addr = r_clr;
        end else if (i_cmd.alloc_wr) begin
            used_we = 1'b1;
            used_wd = 1'b1;
        end else if (i_cmd.unlink) begin
            used_we   = 1'b1;
            used_addr = r_cur[IW-1:0];
        end

        head_we = 1'b0;
        head_wd = PW'(r_idx);
        if (i_cmd.head_wr_slot) begin
            head_we = 1'b1;
        end else if (i_cmd.unlink && prev_nil) begin
            head_we = 1'b1;
            head_wd = r_next_q;
        end
    end

    // node pool memories
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_addr] <= next_wd;
        end
        if (i_cmd.alloc_wr) begin
            r_key_mem[r_idx] <= r_h31;
            r_val_mem[r_idx] <= r_value;
        end
        r_next_q <= r_next_mem[r_cur[IW-1:0]];
        r_key_q  <= r_key_mem[r_cur[IW-1:0]];
        r_val_q  <= r_val_mem[r_cur[IW-1:0]];
    end

    // slot in-use memory
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_addr] <= used_wd;
        end
        r_used_q <= r_used_mem[r_nfs];
    end

    // chain head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[r_bucket] <= head_wd;
        end
        r_head_q     <= r_head_mem[r_bucket];
        r_head_vld_q <= r_head_vld[r_bucket];
    end

    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_done        = r_done;

endmodule

[hw/rtl/chte_ctrl.sv]
// controller state machine sequencing hash, remainder, scan and chain walk
`timescale 1ns / 1ps

module chte_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_key_last,
    input  chte_pkg::t_dp_stat i_stat,
    output chte_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_B,
        S_DIV_P,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_NODE_RD,
        S_NODE_CHK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   is_ins;

    assign is_ins = (i_stat.req == chte_pkg::REQ_INSERT);

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.hash_upd = 1'b1;
                    if (i_key_last) begin
                        o_cmd.div_ld_bkt = 1'b1;
                        n_state          = S_DIV_B;
                    end
                end
            end
            S_DIV_B: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.bkt_save = 1'b1;
                    if (is_ins) begin
                        o_cmd.div_ld_pool = 1'b1;
                        n_state           = S_DIV_P;
                    end else if (i_stat.req inside {chte_pkg::REQ_LOOKUP,
                                                    chte_pkg::REQ_REMOVE}) begin
                        n_state = S_HEAD_RD;
                    end else begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = chte_pkg::STAT_MISS;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_DIV_P: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!i_stat.used_q) begin
                    n_state = S_ALLOC;
                end else if (i_stat.tries_done) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = chte_pkg::STAT_FULL;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                if (i_stat.head_nil) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (is_ins) begin
                        o_cmd.head_wr_slot = 1'b1;
                        o_cmd.status       = chte_pkg::STAT_OK;
                    end else begin
                        o_cmd.status = chte_pkg::STAT_MISS;
                    end
                end else begin
                    o_cmd.cur_from_head = 1'b1;
                    n_state             = S_NODE_RD;
                end
            end
            S_NODE_RD: begin
                n_state = S_NODE_CHK;
            end
            S_NODE_CHK: begin
                if (is_ins) begin
                    // append at the tail of the chain
                    if (i_stat.next_nil) begin
                        o_cmd.link_wr = 1'b1;
                        o_cmd.finish  = 1'b1;
                        o_cmd.status  = chte_pkg::STAT_OK;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_NODE_RD;
                    end
                end else if (i_stat.key_match) begin
                    o_cmd.unlink    = (i_stat.req == chte_pkg::REQ_REMOVE);
                    o_cmd.found_sel = (i_stat.req == chte_pkg::REQ_LOOKUP);
                    o_cmd.finish    = 1'b1;
                    o_cmd.status    = chte_pkg::STAT_OK;
                    n_state         = S_IDLE;
                end else if (i_stat.next_nil) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = chte_pkg::STAT_MISS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_NODE_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

[hw/rtl/chained_hash_table_engine_top.sv]
// Chained hash table engine: key characters in, one result per completed key.
// A character transaction leaves busy low, so the next one can follow at once.
// A key's last transaction runs the restoring remainder of the hash for the bucket; insert then
// runs the remainder for the slot pointer, scans slots for a free one and writes it. The chain
// head is then read and the chain is walked node by node.
// The result shows on o_done for one cycle, as busy falls; the receiver cannot stall.
// After reset, busy stays high while the slot in-use memory is cleared.
`timescale 1ns / 1ps

module chained_hash_table_engine_top #(
    parameter int POOL_DEPTH   = 4096,
    parameter int BUCKET_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic                                i_has_char,
    input  logic signed [chte_pkg::CHAR_W-1:0]  i_key_char,
    input  logic                                i_key_last,
    input  logic [chte_pkg::HASH_W-1:0]         i_entry_value,
    input  logic                                i_cfg_we,
    input  logic [chte_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [chte_pkg::PCFG_W-1:0]         i_cfg_data,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [chte_pkg::HASH_W-1:0]         o_found_value
);

    chte_pkg::t_dp_cmd  cmd;
    chte_pkg::t_dp_stat stat;

    // sequencer
    chte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_key_last (i_key_last),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // datapath and memories
    chte_dp #(
        .POOL_DEPTH   (POOL_DEPTH),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_has_char    (i_has_char),
        .i_key_char    (i_key_char),
        .i_entry_value (i_entry_value),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_done        (o_done)
    );

endmodule

[hw/rtl/chte_checker.sv]
// port-level checks for the chained hash table engine, bound to the top level
`timescale 1ns / 1ps

module chte_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_key_last,
    input logic                        o_done,
    input logic [1:0]                  o_status,
    input logic [chte_pkg::HASH_W-1:0] o_found_value
);

    // a completed key always starts work
    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_key_last) |=> busy)
        else $error("last key transaction did not raise busy");

    // a character transaction never yields a result
    a_char_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_key_last) |=> (!busy && !o_done))
        else $error("character transaction produced a result or busy");

    // a result appears only once work is over
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // single-cycle result strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // only a successful lookup carries a value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != chte_pkg::STAT_OK)) |-> (o_found_value == '0))
        else $error("nonzero value on unsuccessful result");

endmodule

bind chained_hash_table_engine_top chte_checker u_chte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_key_last    (i_key_last),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_found_value (o_found_value)
);

[tb/sv/chained_hash_table_engine_top_tb.sv]
// self-checking testbench for the chained hash table engine
`timescale 1ns / 1ps

module chained_hash_table_engine_top_tb;

    localparam int  POOL_D    = 4096;
    localparam int  BUCKET_D  = 64;
    localparam int  NUM_ITEMS = 450;
    localparam int  CYCLE_CAP = 3000000;
    localparam int  SETTLE    = 16;

    // request code outside the defined set
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
    } t_lookup_res;

    // table mirror: running hashes, chain memory and pending results
    class table_tracker;
        bit [12:0]   heads[BUCKET_D];
        bit [12:0]   nxt[POOL_D];
        bit [31:0]   khash[POOL_D];
        bit [31:0]   val[POOL_D];
        bit          used[POOL_D];
        int unsigned next_free;
        bit [31:0]   h37;
        bit [31:0]   h31;
        bit [6:0]    buckets_reg;
        bit [12:0]   pool_reg;
        t_lookup_res pending_results[$];
        int          n_errors;

        function new();
            foreach (heads[i]) heads[i] = 13'(POOL_D);
            foreach (used[i]) begin
                used[i] = 1'b0;
                nxt[i]  = 13'(POOL_D);
            end
            next_free   = 0;
            h37         = '0;
            h31         = '0;
            buckets_reg = 7'd61;
            pool_reg    = 13'd3400;
            n_errors    = 0;
        endfunction

        function void set_reg(logic [chte_pkg::CFGI_W-1:0] idx,
                              logic [chte_pkg::PCFG_W-1:0] data);
            if (idx == chte_pkg::CFG_BUCKETS) buckets_reg = data[6:0];
            else pool_reg = data;
        endfunction

        // walk the chain for a node matching the current key hash
        function int find_node(int bkt, output int prev);
            int cur;
            int steps;
            cur  = heads[bkt];
            prev = POOL_D;
            for (steps = 0; steps < POOL_D && cur < POOL_D; steps++) begin
                if (khash[cur] == h31) return cur;
                prev = cur;
                cur  = nxt[cur];
            end
            prev = POOL_D;
            return POOL_D;
        endfunction

        function logic [1:0] insert_node(int bkt, logic [31:0] data);
            int pool;
            int slot;
            int idx;
            int cur;
            int steps;
            pool = (pool_reg == 0) ? 1 : (pool_reg > POOL_D) ? POOL_D : int'(pool_reg);
            slot = POOL_D;
            for (int t = 0; t < pool; t++) begin
                idx       = next_free % POOL_D;
                next_free = (next_free + 1) % pool;
                if (!used[idx]) begin
                    slot = idx;
                    break;
                end
            end
            if (slot == POOL_D) return chte_pkg::STAT_FULL;
            used[slot]  = 1'b1;
            nxt[slot]   = 13'(POOL_D);
            khash[slot] = h31;
            val[slot]   = data;
            cur = heads[bkt];
            if (cur >= POOL_D) begin
                heads[bkt] = 13'(slot);
                return chte_pkg::STAT_OK;
            end
            for (steps = 0; steps < POOL_D; steps++) begin
                if (nxt[cur] >= POOL_D) break;
                cur = nxt[cur];
            end
            nxt[cur] = 13'(slot);
            return chte_pkg::STAT_OK;
        endfunction

        // fold one accepted transaction into the table
        function void note_item(logic [1:0] req, logic has, logic [7:0] ch, logic last,
                                logic [31:0] data);
            bit [31:0]   c;
            int          nb;
            int          bkt;
            int          node;
            int          prev;
            t_lookup_res r;
            if (has && ch != 0) begin
                c   = {{24{ch[7]}}, ch};
                h37 = h37 * 37 + c;
                h31 = h31 * 31 + c;
            end
            if (!last) return;
            nb  = (buckets_reg == 0) ? 1 : (buckets_reg > BUCKET_D) ? BUCKET_D :
                  int'(buckets_reg);
            bkt = int'(h37 % nb);
            r.status = chte_pkg::STAT_MISS;
            r.value  = '0;
            case (req)
                chte_pkg::REQ_INSERT: r.status = insert_node(bkt, data);
                chte_pkg::REQ_LOOKUP: begin
                    node = find_node(bkt, prev);
                    if (node < POOL_D) begin
                        r.status = chte_pkg::STAT_OK;
                        r.value  = val[node];
                    end
                end
                chte_pkg::REQ_REMOVE: begin
                    node = find_node(bkt, prev);
                    if (node < POOL_D) begin
                        if (prev >= POOL_D) heads[bkt] = nxt[node];
                        else nxt[prev] = nxt[node];
                        used[node] = 1'b0;
                        r.status   = chte_pkg::STAT_OK;
                    end
                end
                default: ;
            endcase
            h37 = '0;
            h31 = '0;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] data);
            t_lookup_res e;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result with no transaction pending: status %0d value %h",
                             status, data);
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status || data !== e.value) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: status exp %0d got %0d, value exp %h got %h",
                             e.status, status, e.value, data);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n       = 1'b0;
    logic                               start         = 1'b0;
    logic                               busy;
    logic [1:0]                         i_req_type    = '0;
    logic                               i_has_char    = 1'b0;
    logic signed [chte_pkg::CHAR_W-1:0] i_key_char    = '0;
    logic                               i_key_last    = 1'b0;
    logic [chte_pkg::HASH_W-1:0]        i_entry_value = '0;
    logic                               i_cfg_we      = 1'b0;
    logic [chte_pkg::CFGI_W-1:0]        i_cfg_index   = '0;
    logic [chte_pkg::PCFG_W-1:0]        i_cfg_data    = '0;
    logic                               o_done;
    logic [1:0]                         o_status;
    logic [chte_pkg::HASH_W-1:0]        o_found_value;

    table_tracker tracker = new();
    int           n_items = 0;
    int           n_cycles = 0;
    bit           gaps_on = 1;
    bit [63:0]    key_bank[$];
    int           key_len[$];

    chained_hash_table_engine_top uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // transaction monitor and result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_status, o_found_value);
        if (i_rst_n && start && !busy)
            tracker.note_item(i_req_type, i_has_char, i_key_char, i_key_last, i_entry_value);
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // idle gap after a transaction, mostly short
    task automatic idle_gap();
        int r;
        int g;
        r = $urandom_range(99);
        g = 0;
        if (gaps_on) begin
            if (r < 60) g = 0;
            else if (r < 90) g = $urandom_range(3, 1);
            else if (r < 97) g = $urandom_range(10, 4);
            else g = $urandom_range(60, 20);
        end
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_item(logic [1:0] req, logic has, logic [7:0] ch, logic last,
                             logic [31:0] data);
        i_req_type    <= req;
        i_has_char    <= has;
        i_key_char    <= ch;
        i_key_last    <= last;
        i_entry_value <= data;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
        idle_gap();
    endtask

    // key characters then the request, ended on the last char or an empty item
    task automatic send_key(bit [63:0] key, int len, logic [1:0] req, logic [31:0] data);
        bit on_char;
        on_char = $urandom_range(1) && len > 0;
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && on_char) send_item(req, 1'b1, key[8*i +: 8], 1'b1, data);
            else send_item(2'($urandom_range(3)), 1'b1, key[8*i +: 8], 1'b0, $urandom);
        end
        if (!on_char) send_item(req, 1'b0, 8'($urandom), 1'b1, data);
    endtask

    // wait until the block is idle and every expected result has come
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [chte_pkg::CFGI_W-1:0] idx,
                             logic [chte_pkg::PCFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void make_key(output bit [63:0] key, output int len);
        len = $urandom_range(6, 1);
        key = '0;
        for (int i = 0; i < len; i++) key[8*i +: 8] = 8'($urandom_range(255, 1));
    endfunction

    // stimulus
    initial begin
        bit [63:0] k;
        int        kl;
        int        sel;
        int        r;
        bit [6:0]  bucket_cfg[6];
        bit [12:0] pool_cfg[6];

        bucket_cfg = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd13, 7'd5};
        pool_cfg   = '{13'd0, 13'd8191, 13'd4, 13'd4096, 13'd37, 13'd3};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty keys, zero and extreme characters, misses, unknown request
        send_item(chte_pkg::REQ_LOOKUP, 1'b0, 8'h00, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_INSERT, 1'b0, 8'h00, 1'b1, 32'hFFFF_FFFF);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h00, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_INSERT, 1'b1, 8'h80, 1'b0, 32'h0);
        send_item(chte_pkg::REQ_INSERT, 1'b1, 8'h7F, 1'b1, 32'hA5A5_5A5A);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h80, 1'b0, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h00, 1'b0, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h7F, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'hFF, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_REMOVE, 1'b1, 8'hFF, 1'b1, 32'h1234_5678);
        send_item(REQ_UNUSED, 1'b1, 8'h01, 1'b1, 32'hFFFF_FFFF);
        send_item(chte_pkg::REQ_REMOVE, 1'b0, 8'h55, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b0, 8'hAA, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_REMOVE, 1'b0, 8'h00, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_INSERT, 1'b0, 8'h00, 1'b1, 32'h0000_0001);
        send_item(chte_pkg::REQ_INSERT, 1'b0, 8'h00, 1'b1, 32'h8000_0000);
        send_item(chte_pkg::REQ_LOOKUP, 1'b0, 8'h00, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_REMOVE, 1'b1, 8'h80, 1'b0, 32'h0);
        send_item(chte_pkg::REQ_REMOVE, 1'b1, 8'h7F, 1'b1, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h80, 1'b0, 32'h0);
        send_item(chte_pkg::REQ_LOOKUP, 1'b1, 8'h7F, 1'b1, 32'h0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(chte_pkg::CFG_BUCKETS, {6'd0, bucket_cfg[ph]});
            write_reg(chte_pkg::CFG_POOL, pool_cfg[ph]);
            gaps_on = (ph != 3);
            while (n_items < 21 + (ph + 1) * (NUM_ITEMS - 21) / 6) begin
                sel = $urandom_range(99);
                if (sel < 45 || key_bank.size() == 0) begin
                    make_key(k, kl);
                    key_bank.push_back(k);
                    key_len.push_back(kl);
                    send_key(k, kl, chte_pkg::REQ_INSERT, $urandom);
                end else if (sel < 90) begin
                    r = $urandom_range(key_bank.size() - 1);
                    send_key(key_bank[r], key_len[r],
                             (sel < 72) ? chte_pkg::REQ_LOOKUP : chte_pkg::REQ_REMOVE,
                             $urandom);
                end else if (sel < 96) begin
                    // noise: stray characters, unknown requests and empty keys
                    send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom),
                              1'($urandom_range(1)), $urandom);
                end else begin
                    make_key(k, kl);
                    send_key(k, kl, 2'($urandom_range(3)), $urandom);
                end
                if (key_bank.size() > 24) begin
                    key_bank.delete(0);
                    key_len.delete(0);
                end
                // in phase 2 the sender now and then holds off until everything outstanding has come back
                if (ph == 2 && $urandom_range(19) == 0) drain();
            end
        end

        drain();
        if (tracker.n_errors == 0 && tracker.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
